### rtl/rmq_pkg.sv
// Types and constants shared by the rotation-to-quaternion pipeline.
package rmq_pkg;

   localparam int ROT_W  = 16;                 // Q1.14 element
   localparam int TRN_W  = 32;                 // Q16.16 translation
   localparam int TOL_W  = 29;
   localparam int PRD_W  = 32;                 // element product
   localparam int SUM_W  = 34;                 // sum of three products
   localparam int DEV_W  = 35;
   localparam int T_W    = 19;                 // 1 + signed diagonal sum
   localparam int D_W    = 18;                 // off-diagonal sum or difference
   localparam int MAG_W  = 17;
   localparam int SQ_W   = 23;                 // root bits
   localparam int RAD_W  = 2 * SQ_W;
   localparam int REM_W  = SQ_W + 2;
   localparam int DQ_W   = 23;                 // quotient bits
   localparam int NUM_W  = 37;
   localparam int DREM_W = SQ_W + 1;
   localparam int FRAC_SH = 20;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(268435);
   localparam logic signed [T_W-1:0] ONE_Q14 = T_W'(16384);
   localparam logic signed [DEV_W-1:0] ONE_Q28 = DEV_W'(268435456);

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NON_UNIT  = 2'd1,
      STAT_NON_ORTHO = 2'd2
   } stat_type;

   typedef enum logic [1:0] {
      DOM_X = 2'd0,
      DOM_Y = 2'd1,
      DOM_Z = 2'd2,
      DOM_W = 2'd3
   } dom_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] rot_r0c0;
      logic signed [ROT_W-1:0] rot_r0c1;
      logic signed [ROT_W-1:0] rot_r0c2;
      logic signed [ROT_W-1:0] rot_r1c0;
      logic signed [ROT_W-1:0] rot_r1c1;
      logic signed [ROT_W-1:0] rot_r1c2;
      logic signed [ROT_W-1:0] rot_r2c0;
      logic signed [ROT_W-1:0] rot_r2c1;
      logic signed [ROT_W-1:0] rot_r2c2;
      logic signed [TRN_W-1:0] trans_x;
      logic signed [TRN_W-1:0] trans_y;
      logic signed [TRN_W-1:0] trans_z;
   } req_type;

   typedef struct packed {
      logic signed [TRN_W-1:0] pos_x;
      logic signed [TRN_W-1:0] pos_y;
      logic signed [TRN_W-1:0] pos_z;
      logic signed [ROT_W-1:0] quat_x;
      logic signed [ROT_W-1:0] quat_y;
      logic signed [ROT_W-1:0] quat_z;
      logic signed [ROT_W-1:0] quat_w;
      logic [1:0]              status;
   } rsp_type;

   // Side data that rides alongside the arithmetic
   typedef struct packed {
      stat_type                 status;
      dom_type                  dom;
      logic [2:0][D_W-1:0]      d;
      logic signed [TRN_W-1:0]  trans_x;
      logic signed [TRN_W-1:0]  trans_y;
      logic signed [TRN_W-1:0]  trans_z;
   } ctl_type;

endpackage

### rtl/rotation_matrix_to_quaternion_unit.sv
// Rigid transform checker and rotation-to-quaternion converter, top level.
//
// Input beats on req_valid/req_ready carry a row-major Q1.14 rotation and a
// Q16.16 translation. Each produces one beat on rsp_valid/rsp_ready holding
// the translation, the Q1.14 quaternion and a status (ok, non-unit row, rows
// not orthogonal); on a failed check every pose field is zero.
// csr_valid/csr_ready/csr_data writes the orthonormality tolerance
// (units of 2^-28); csr_ready is always high.
// The path from the accepting edge to rsp_valid runs through 52 register
// stages: input register, products, sums, checks, 23 square-root
// stages (one root bit each), divider setup, 23 divider stages (one quotient
// bit each) and the output register.
// Throughput is one beat per cycle. All stages advance together; while a
// response beat waits with rsp_ready low the whole pipeline holds and
// req_ready drops, so nothing is lost or repeated.
// Synchronous active-high reset empties the pipeline and restores the
// tolerance to about 1e-3.
module rotation_matrix_to_quaternion_unit
   import rmq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TOL_W-1:0]  csr_data
);

   logic              adv;
   logic [TOL_W-1:0]  tol_ff;

   // stage 1: input
   logic              v1_ff;
   req_type           r1_ff;
   // stage 2: products
   logic              v2_ff;
   req_type           r2_ff;
   logic signed [PRD_W-1:0] sq2_ff [3][3];
   logic signed [PRD_W-1:0] dp2_ff [3][3];
   // stage 3: sums and branch choice
   logic              v3_ff;
   logic signed [SUM_W-1:0] len3_ff [3];
   logic signed [SUM_W-1:0] dot3_ff [3];
   logic signed [T_W-1:0]   t3_ff;
   ctl_type           ctl3_ff;
   // stage 4: checks and radicand
   logic              v4_ff;
   ctl_type           ctl4_ff;
   logic [RAD_W-1:0]  rad4_ff;
   // square root
   logic              sv_ff    [SQ_W];
   ctl_type           sctl_ff  [SQ_W];
   logic [REM_W-1:0]  srem_ff  [SQ_W];
   logic [SQ_W-1:0]   sroot_ff [SQ_W];
   logic [RAD_W-1:0]  srad_ff  [SQ_W];
   logic [REM_W-1:0]  srem_in  [SQ_W];
   logic [SQ_W-1:0]   sroot_in [SQ_W];
   logic [RAD_W-1:0]  srad_in  [SQ_W];
   // divider setup
   logic              v5_ff;
   ctl_type           ctl5_ff;
   logic [SQ_W-1:0]   den5_ff;
   logic [ROT_W-1:0]  big5_ff;
   logic [2:0]        neg5_ff;
   logic [DREM_W-1:0] rem5_ff [3];
   logic [DQ_W-1:0]   low5_ff [3];
   logic [ROT_W-1:0]  big5_in;
   logic [2:0]        neg5_in;
   logic [DREM_W-1:0] rem5_in [3];
   logic [DQ_W-1:0]   low5_in [3];
   // divider
   logic              dv_ff   [DQ_W];
   ctl_type           dctl_ff [DQ_W];
   logic [SQ_W-1:0]   dden_ff [DQ_W];
   logic [ROT_W-1:0]  dbig_ff [DQ_W];
   logic [2:0]        dneg_ff [DQ_W];
   logic [DREM_W-1:0] drem_ff [DQ_W][3];
   logic [DQ_W-1:0]   dlow_ff [DQ_W][3];
   logic [DQ_W-1:0]   dquo_ff [DQ_W][3];
   logic [DREM_W-1:0] drem_in [DQ_W][3];
   logic [DQ_W-1:0]   dlow_in [DQ_W][3];
   logic [DQ_W-1:0]   dquo_in [DQ_W][3];
   // output
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic signed [ROT_W-1:0] rv1 [3][3];
   logic signed [ROT_W-1:0] rv2 [3][3];
   logic signed [SUM_W-1:0] len3_in [3];
   logic signed [SUM_W-1:0] dot3_in [3];
   logic signed [T_W-1:0]   t3_in;
   ctl_type                 ctl3_in;
   ctl_type                 ctl4_in;
   logic [RAD_W-1:0]        rad4_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   always_comb begin
      rv1[0][0] = r1_ff.rot_r0c0; rv1[0][1] = r1_ff.rot_r0c1; rv1[0][2] = r1_ff.rot_r0c2;
      rv1[1][0] = r1_ff.rot_r1c0; rv1[1][1] = r1_ff.rot_r1c1; rv1[1][2] = r1_ff.rot_r1c2;
      rv1[2][0] = r1_ff.rot_r2c0; rv1[2][1] = r1_ff.rot_r2c1; rv1[2][2] = r1_ff.rot_r2c2;
      rv2[0][0] = r2_ff.rot_r0c0; rv2[0][1] = r2_ff.rot_r0c1; rv2[0][2] = r2_ff.rot_r0c2;
      rv2[1][0] = r2_ff.rot_r1c0; rv2[1][1] = r2_ff.rot_r1c1; rv2[1][2] = r2_ff.rot_r1c2;
      rv2[2][0] = r2_ff.rot_r2c0; rv2[2][1] = r2_ff.rot_r2c1; rv2[2][2] = r2_ff.rot_r2c2;
   end

   // stage 3: row lengths, row dots, Shepperd branch
   always_comb begin
      logic signed [T_W-1:0] trace;
      logic signed [T_W-1:0] d00;
      logic signed [T_W-1:0] d11;
      logic signed [T_W-1:0] d22;
      for (int i = 0; i < 3; i++) begin
         len3_in[i] = SUM_W'(sq2_ff[i][0]) + SUM_W'(sq2_ff[i][1]) + SUM_W'(sq2_ff[i][2]);
         dot3_in[i] = SUM_W'(dp2_ff[i][0]) + SUM_W'(dp2_ff[i][1]) + SUM_W'(dp2_ff[i][2]);
      end
      d00   = T_W'(rv2[0][0]);
      d11   = T_W'(rv2[1][1]);
      d22   = T_W'(rv2[2][2]);
      trace = d00 + d11 + d22;
      ctl3_in         = '0;
      ctl3_in.status  = STAT_OK;
      ctl3_in.trans_x = r2_ff.trans_x;
      ctl3_in.trans_y = r2_ff.trans_y;
      ctl3_in.trans_z = r2_ff.trans_z;
      if (trace > 0) begin
         ctl3_in.dom  = DOM_W;
         t3_in        = ONE_Q14 + trace;
         ctl3_in.d[0] = D_W'(rv2[2][1]) - D_W'(rv2[1][2]);
         ctl3_in.d[1] = D_W'(rv2[0][2]) - D_W'(rv2[2][0]);
         ctl3_in.d[2] = D_W'(rv2[1][0]) - D_W'(rv2[0][1]);
      end else if (d00 > d11 && d00 > d22) begin
         ctl3_in.dom  = DOM_X;
         t3_in        = ONE_Q14 + d00 - d11 - d22;
         ctl3_in.d[0] = D_W'(rv2[0][1]) + D_W'(rv2[1][0]);
         ctl3_in.d[1] = D_W'(rv2[0][2]) + D_W'(rv2[2][0]);
         ctl3_in.d[2] = D_W'(rv2[2][1]) - D_W'(rv2[1][2]);
      end else if (d11 > d22) begin
         ctl3_in.dom  = DOM_Y;
         t3_in        = ONE_Q14 + d11 - d00 - d22;
         ctl3_in.d[0] = D_W'(rv2[0][1]) + D_W'(rv2[1][0]);
         ctl3_in.d[1] = D_W'(rv2[1][2]) + D_W'(rv2[2][1]);
         ctl3_in.d[2] = D_W'(rv2[0][2]) - D_W'(rv2[2][0]);
      end else begin
         ctl3_in.dom  = DOM_Z;
         t3_in        = ONE_Q14 + d22 - d00 - d11;
         ctl3_in.d[0] = D_W'(rv2[0][2]) + D_W'(rv2[2][0]);
         ctl3_in.d[1] = D_W'(rv2[1][2]) + D_W'(rv2[2][1]);
         ctl3_in.d[2] = D_W'(rv2[1][0]) - D_W'(rv2[0][1]);
      end
   end

   // stage 4: tolerance checks, first failure wins
   always_comb begin
      logic signed [DEV_W-1:0] dev;
      logic [DEV_W-1:0]        mag;
      logic [2:0]              bad_len;
      logic [2:0]              bad_dot;
      for (int i = 0; i < 3; i++) begin
         dev        = DEV_W'(len3_ff[i]) - ONE_Q28;
         mag        = dev < 0 ? DEV_W'(-dev) : DEV_W'(dev);
         bad_len[i] = mag > DEV_W'(tol_ff);
         dev        = DEV_W'(dot3_ff[i]);
         mag        = dev < 0 ? DEV_W'(-dev) : DEV_W'(dev);
         bad_dot[i] = mag > DEV_W'(tol_ff);
      end
      ctl4_in = ctl3_ff;
      if (|bad_len) begin
         ctl4_in.status = STAT_NON_UNIT;
      end else if (|bad_dot) begin
         ctl4_in.status = STAT_NON_ORTHO;
      end
      if (t3_ff > 0) begin
         rad4_in = RAD_W'({t3_ff[T_W-3:0], 28'd0});
      end else begin
         rad4_in = '0;
      end
   end

   // square root, one root bit per stage
   always_comb begin
      logic [REM_W-1:0] rem_p;
      logic [SQ_W-1:0]  root_p;
      logic [RAD_W-1:0] rad_p;
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] tst;
      for (int k = 0; k < SQ_W; k++) begin
         if (k == 0) begin
            rem_p  = '0;
            root_p = '0;
            rad_p  = rad4_ff;
         end else begin
            rem_p  = srem_ff[k-1];
            root_p = sroot_ff[k-1];
            rad_p  = srad_ff[k-1];
         end
         sh  = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
         tst = {root_p, 2'b01};
         if (sh >= tst) begin
            srem_in[k]  = sh - tst;
            sroot_in[k] = {root_p[SQ_W-2:0], 1'b1};
         end else begin
            srem_in[k]  = sh;
            sroot_in[k] = {root_p[SQ_W-2:0], 1'b0};
         end
         srad_in[k] = {rad_p[RAD_W-3:0], 2'b00};
      end
   end

   // divider setup: magnitude, half-divisor bias, dominant term
   always_comb begin
      logic [SQ_W-1:0]  s;
      logic [SQ_W:0]    bsum;
      logic [D_W-1:0]   mag;
      logic [NUM_W-1:0] num;
      s       = sroot_ff[SQ_W-1];
      bsum    = {1'b0, s} + (SQ_W+1)'(128);
      big5_in = bsum[SQ_W -: ROT_W];
      for (int j = 0; j < 3; j++) begin
         neg5_in[j] = sctl_ff[SQ_W-1].d[j][D_W-1];
         mag        = neg5_in[j] ? D_W'(-$signed(sctl_ff[SQ_W-1].d[j]))
                                 : sctl_ff[SQ_W-1].d[j];
         num        = {mag[MAG_W-1:0], FRAC_SH'(0)} + NUM_W'(s >> 1);
         rem5_in[j] = DREM_W'(num[NUM_W-1:DQ_W]);
         low5_in[j] = num[DQ_W-1:0];
      end
   end

   // restoring division, one quotient bit per stage
   always_comb begin
      logic [DREM_W-1:0] rem_p;
      logic [DQ_W-1:0]   low_p;
      logic [DQ_W-1:0]   quo_p;
      logic [SQ_W-1:0]   den_p;
      logic [DREM_W-1:0] sh;
      for (int k = 0; k < DQ_W; k++) begin
         for (int j = 0; j < 3; j++) begin
            if (k == 0) begin
               rem_p = rem5_ff[j];
               low_p = low5_ff[j];
               quo_p = '0;
               den_p = den5_ff;
            end else begin
               rem_p = drem_ff[k-1][j];
               low_p = dlow_ff[k-1][j];
               quo_p = dquo_ff[k-1][j];
               den_p = dden_ff[k-1];
            end
            sh = {rem_p[DREM_W-2:0], low_p[DQ_W-1]};
            if (sh >= {1'b0, den_p}) begin
               drem_in[k][j] = sh - {1'b0, den_p};
               dquo_in[k][j] = {quo_p[DQ_W-2:0], 1'b1};
            end else begin
               drem_in[k][j] = sh;
               dquo_in[k][j] = {quo_p[DQ_W-2:0], 1'b0};
            end
            dlow_in[k][j] = {low_p[DQ_W-2:0], 1'b0};
         end
      end
   end

   // output: sign, saturate, place the dominant term
   always_comb begin
      logic signed [ROT_W-1:0] oth [3];
      logic signed [ROT_W-1:0] big;
      logic [DQ_W-1:0]         q;
      ctl_type                 c;
      c = dctl_ff[DQ_W-1];
      for (int j = 0; j < 3; j++) begin
         q = dquo_ff[DQ_W-1][j];
         if (!dneg_ff[DQ_W-1][j]) begin
            oth[j] = (q > DQ_W'(32767)) ? 16'sh7fff : $signed(q[ROT_W-1:0]);
         end else begin
            oth[j] = (q >= DQ_W'(32768)) ? 16'sh8000 : $signed(-q[ROT_W-1:0]);
         end
      end
      big = dbig_ff[DQ_W-1][ROT_W-1] ? 16'sh7fff : $signed(dbig_ff[DQ_W-1]);
      rsp_data_in        = '0;
      rsp_data_in.status = c.status;
      if (c.status == STAT_OK) begin
         rsp_data_in.pos_x = c.trans_x;
         rsp_data_in.pos_y = c.trans_y;
         rsp_data_in.pos_z = c.trans_z;
         if (dden_ff[DQ_W-1] != '0) begin
            case (c.dom)
               DOM_X: begin
                  rsp_data_in.quat_x = big;    rsp_data_in.quat_y = oth[0];
                  rsp_data_in.quat_z = oth[1]; rsp_data_in.quat_w = oth[2];
               end
               DOM_Y: begin
                  rsp_data_in.quat_x = oth[0]; rsp_data_in.quat_y = big;
                  rsp_data_in.quat_z = oth[1]; rsp_data_in.quat_w = oth[2];
               end
               DOM_Z: begin
                  rsp_data_in.quat_x = oth[0]; rsp_data_in.quat_y = oth[1];
                  rsp_data_in.quat_z = big;    rsp_data_in.quat_w = oth[2];
               end
               default: begin
                  rsp_data_in.quat_x = oth[0]; rsp_data_in.quat_y = oth[1];
                  rsp_data_in.quat_z = oth[2]; rsp_data_in.quat_w = big;
               end
            endcase
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SQ_W; k++) sv_ff[k] <= 1'b0;
         for (int k = 0; k < DQ_W; k++) dv_ff[k] <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         for (int k = 0; k < SQ_W; k++) sv_ff[k] <= (k == 0) ? v4_ff : sv_ff[k-1];
         v5_ff <= sv_ff[SQ_W-1];
         for (int k = 0; k < DQ_W; k++) dv_ff[k] <= (k == 0) ? v5_ff : dv_ff[k-1];
         rsp_valid_ff <= dv_ff[DQ_W-1];
      end
   end

   // payload, hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff <= req_data;
         r2_ff <= r1_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               sq2_ff[i][j] <= rv1[i][j] * rv1[i][j];
            end
            dp2_ff[0][i] <= rv1[0][i] * rv1[1][i];
            dp2_ff[1][i] <= rv1[0][i] * rv1[2][i];
            dp2_ff[2][i] <= rv1[1][i] * rv1[2][i];
            len3_ff[i]   <= len3_in[i];
            dot3_ff[i]   <= dot3_in[i];
         end
         t3_ff   <= t3_in;
         ctl3_ff <= ctl3_in;
         ctl4_ff <= ctl4_in;
         rad4_ff <= rad4_in;
         for (int k = 0; k < SQ_W; k++) begin
            sctl_ff[k]  <= (k == 0) ? ctl4_ff : sctl_ff[k-1];
            srem_ff[k]  <= srem_in[k];
            sroot_ff[k] <= sroot_in[k];
            srad_ff[k]  <= srad_in[k];
         end
         ctl5_ff <= sctl_ff[SQ_W-1];
         den5_ff <= sroot_ff[SQ_W-1];
         big5_ff <= big5_in;
         neg5_ff <= neg5_in;
         for (int j = 0; j < 3; j++) begin
            rem5_ff[j] <= rem5_in[j];
            low5_ff[j] <= low5_in[j];
         end
         for (int k = 0; k < DQ_W; k++) begin
            dctl_ff[k] <= (k == 0) ? ctl5_ff : dctl_ff[k-1];
            dden_ff[k] <= (k == 0) ? den5_ff : dden_ff[k-1];
            dbig_ff[k] <= (k == 0) ? big5_ff : dbig_ff[k-1];
            dneg_ff[k] <= (k == 0) ? neg5_ff : dneg_ff[k-1];
            for (int j = 0; j < 3; j++) begin
               drem_ff[k][j] <= drem_in[k][j];
               dlow_ff[k][j] <= dlow_in[k][j];
               dquo_ff[k][j] <= dquo_in[k][j];
            end
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
